@@ hw/rtl/rsp_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rsp_pkg: shared constants and types of the road segment projection
// Fixed-point formats, pipeline word layouts and register indexes.
// ----------------------------------------------------------------------------
package rsp_pkg;

  // Fixed-point and angle formats
  localparam int FRAC_BITS   = 8;
  localparam int ANGLE_BITS  = 12;
  localparam int ANGLE_STEPS = 1 << ANGLE_BITS;
  localparam int PHASE_W     = 16;
  localparam int TRIG_W      = 18;

  // Quarter-wave sine polynomial coefficients (Q14 argument, Q16 result)
  localparam int SIN_A = 102944;
  localparam int SIN_B = 42177;
  localparam int SIN_C = 4769;

  // Datapath widths
  localparam int DELTA_W   = 33 + FRAC_BITS;          // seg - cam * 2^F
  localparam int ROT_W     = DELTA_W + 2;             // rotated coordinates
  localparam int MIN_DEPTH = ((1 << FRAC_BITS) + 5) / 10;
  localparam int QUO_W     = 25 + FRAC_BITS;          // quotient bits of 2^(24+F)/tz
  localparam int DIV_W     = 26 + FRAC_BITS;          // divisor after clip
  localparam int SCALE_W   = 28;
  localparam int RATIO_W   = 34;
  localparam int W_SHIFT   = 25 - FRAC_BITS;
  localparam int SW_W      = 13;
  localparam int RW_W      = 16;
  localparam int RWSW_W    = RW_W + SW_W;

  // Configuration port
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_CAM_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CAM_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CAM_Z   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HEADING = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCR_W   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SCR_H   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ROAD_W  = 3'd6;

  // Word carried alongside the reciprocal
  typedef struct packed {
    logic signed [ROT_W-1:0]   tx;
    logic signed [DELTA_W-1:0] dy;
    logic [30:0]               depth;
    logic                      clamped;
  } rsp_carry_t;

  // Word leaving the rotation stages
  typedef struct packed {
    rsp_carry_t        carry;
    logic [DIV_W-1:0]  tzd;
  } rsp_rot_t;

  // Final result word
  typedef struct packed {
    logic signed [31:0] lateral;
    logic [30:0]        depth;
    logic               clamped;
    logic [SCALE_W-1:0] scale;
    logic signed [31:0] screen_x;
    logic signed [31:0] screen_y;
    logic [30:0]        road_w;
  } rsp_result_t;

endpackage
`default_nettype wire

@@ hw/rtl/rsp_trig.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rsp_trig: four-stage sine evaluator
// Quarter-wave polynomial sin(phase), giving the signed value.
// ----------------------------------------------------------------------------
module rsp_trig (
  input  logic                               clk,
  input  logic                               en,
  input  logic [rsp_pkg::PHASE_W-1:0]        phase,
  output logic signed [rsp_pkg::TRIG_W-1:0]  pos_o
);
  import rsp_pkg::*;

  logic [1:0]  quad;
  logic [13:0] frac;
  logic [14:0] x;
  logic [29:0] sq;
  logic [27:0] m1;
  logic [15:0] t2;
  logic [30:0] m2;
  logic [16:0] t4;
  logic [31:0] m3;
  logic signed [TRIG_W-1:0] val;

  logic [14:0] x_1_r, x2_1_r, x_2_r, x2_2_r, x_3_r;
  logic [15:0] t2_r;
  logic [16:0] t4_r;
  logic        ng_1_r, ng_2_r, ng_3_r;
  logic signed [TRIG_W-1:0] pos_r;

  // Fold the phase into the first quarter and square it
  always_comb begin
    quad = phase[15:14];
    frac = phase[13:0];
    x    = quad[0] ? 15'(15'd16384 - {1'b0, frac}) : {1'b0, frac};
    sq   = 30'(x) * 30'(x);
  end

  // Inner polynomial terms
  always_comb begin
    m1  = 28'(x2_1_r) * 28'(SIN_C);
    t2  = 16'(SIN_B) - 16'(m1[27:14]);
    m2  = 31'(t2_r) * 31'(x2_2_r);
    t4  = 17'(SIN_A) - m2[30:14];
    m3  = 32'(t4_r) * 32'(x_3_r);
    val = $signed(m3[31:14]);
  end

  // Advance the stages
  always_ff @(posedge clk) begin
    if (en) begin
      x_1_r  <= x;
      x2_1_r <= sq[28:14];
      ng_1_r <= quad[1];
      x_2_r  <= x_1_r;
      x2_2_r <= x2_1_r;
      t2_r   <= t2;
      ng_2_r <= ng_1_r;
      x_3_r  <= x_2_r;
      t4_r   <= t4;
      ng_3_r <= ng_2_r;
      pos_r  <= ng_3_r ? -val : val;
    end
  end

  assign pos_o = pos_r;

endmodule
`default_nettype wire

@@ hw/rtl/rsp_rotate.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rsp_rotate: camera offset, heading rotation and depth clamp
// Seven stages: offset, three trig wait stages, partial products, sums,
// clamp and divisor clip.
// ----------------------------------------------------------------------------
module rsp_rotate (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                in_vld,
  input  logic signed [31:0]                  seg_x,
  input  logic signed [31:0]                  seg_y,
  input  logic signed [31:0]                  seg_z,
  input  logic signed [31:0]                  cam_x,
  input  logic signed [31:0]                  cam_y,
  input  logic signed [31:0]                  cam_z,
  input  logic [rsp_pkg::ANGLE_BITS-1:0]      heading,
  output logic                                out_vld,
  output rsp_pkg::rsp_rot_t                   out_word
);
  import rsp_pkg::*;

  localparam int HP_W = DELTA_W - 16 + TRIG_W;
  localparam int LP_W = 17 + TRIG_W;
  localparam int NSTG = 7;
  localparam logic [PHASE_W-1:0] QUARTER = PHASE_W'(1 << (PHASE_W - 2));
  localparam logic signed [ROT_W-1:0] MIN_T     = ROT_W'(MIN_DEPTH);
  localparam logic signed [ROT_W-1:0] DEPTH_MAX = ROT_W'(32'h7FFF_FFFF);
  localparam logic signed [ROT_W-1:0] CLIP_T    = ROT_W'(1) <<< (DIV_W - 1);

  logic [NSTG-1:0] vld_r;
  logic [PHASE_W-1:0] ph_s, ph_c;
  logic signed [TRIG_W-1:0] sin_p, cos_p;

  logic signed [DELTA_W-1:0] dx_nxt, dy_nxt, dz_nxt;
  logic signed [DELTA_W-1:0] dx_r [4];
  logic signed [DELTA_W-1:0] dy_r [4];
  logic signed [DELTA_W-1:0] dz_r [4];

  logic signed [DELTA_W-17:0] hx, hz;
  logic [15:0] lx, lz;
  logic signed [HP_W-1:0] a1_r, a2_r, a3_r, a4_r;
  logic signed [LP_W-1:0] b1_r, b2_r, b3_r, b4_r;
  logic signed [DELTA_W-1:0] dy5_r, dy6_r;

  logic signed [LP_W:0] bx, bz;
  logic signed [ROT_W-1:0] tx_nxt, tz_nxt, tx_r, tz_r, tzc;
  logic lt;
  rsp_rot_t word_nxt, word_r;

  // Phase of sine and cosine
  assign ph_s = PHASE_W'(heading) << (PHASE_W - ANGLE_BITS);
  assign ph_c = ph_s + QUARTER;

  rsp_trig u_sin (.clk(clk), .en(en), .phase(ph_s), .pos_o(sin_p));
  rsp_trig u_cos (.clk(clk), .en(en), .phase(ph_c), .pos_o(cos_p));

  // Offset from camera in Q.F
  always_comb begin
    dx_nxt = DELTA_W'(seg_x) - (DELTA_W'(cam_x) <<< FRAC_BITS);
    dy_nxt = DELTA_W'(seg_y) - (DELTA_W'(cam_y) <<< FRAC_BITS);
    dz_nxt = DELTA_W'(seg_z) - (DELTA_W'(cam_z) <<< FRAC_BITS);
  end

  // Split offsets into high and low halves for the products
  always_comb begin
    hx = $signed(dx_r[3][DELTA_W-1:16]);
    hz = $signed(dz_r[3][DELTA_W-1:16]);
    lx = dx_r[3][15:0];
    lz = dz_r[3][15:0];
  end

  // Combine partial products: floor((a*ca + b*cb) / 2^16); depth subtracts the sine terms
  always_comb begin
    bx     = (LP_W+1)'(b1_r) + (LP_W+1)'(b2_r);
    bz     = (LP_W+1)'(b3_r) - (LP_W+1)'(b4_r);
    tx_nxt = ROT_W'(a1_r) + ROT_W'(a2_r) + ROT_W'(bx >>> 16);
    tz_nxt = ROT_W'(a3_r) - ROT_W'(a4_r) + ROT_W'(bz >>> 16);
  end

  // Raise depth to the minimum, saturate the reported depth, clip divisor
  always_comb begin
    lt  = tz_r < MIN_T;
    tzc = lt ? MIN_T : tz_r;
    word_nxt.carry.tx      = tx_r;
    word_nxt.carry.dy      = dy6_r;
    word_nxt.carry.clamped = lt;
    word_nxt.carry.depth   = (tzc > DEPTH_MAX) ? '1 : tzc[30:0];
    word_nxt.tzd           = (tzc >= CLIP_T) ? CLIP_T[DIV_W-1:0] : tzc[DIV_W-1:0];
  end

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NSTG-2:0], in_vld};
    end
  end

  // Data stages
  always_ff @(posedge clk) begin
    if (en) begin
      dx_r[0] <= dx_nxt;
      dy_r[0] <= dy_nxt;
      dz_r[0] <= dz_nxt;
      for (int i = 1; i < 4; i++) begin
        dx_r[i] <= dx_r[i-1];
        dy_r[i] <= dy_r[i-1];
        dz_r[i] <= dz_r[i-1];
      end
      a1_r  <= HP_W'(hx) * HP_W'(cos_p);
      a2_r  <= HP_W'(hz) * HP_W'(sin_p);
      b1_r  <= LP_W'($signed({1'b0, lx})) * LP_W'(cos_p);
      b2_r  <= LP_W'($signed({1'b0, lz})) * LP_W'(sin_p);
      a3_r  <= HP_W'(hz) * HP_W'(cos_p);
      a4_r  <= HP_W'(hx) * HP_W'(sin_p);
      b3_r  <= LP_W'($signed({1'b0, lz})) * LP_W'(cos_p);
      b4_r  <= LP_W'($signed({1'b0, lx})) * LP_W'(sin_p);
      dy5_r <= dy_r[3];
      tx_r  <= tx_nxt;
      tz_r  <= tz_nxt;
      dy6_r <= dy5_r;
      word_r <= word_nxt;
    end
  end

  assign out_vld  = vld_r[NSTG-1];
  assign out_word = word_r;

endmodule
`default_nettype wire

@@ hw/rtl/rsp_recip.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rsp_recip: pipelined restoring divider for the scale
// One quotient bit per stage of floor(2^(24+F) / depth), saturated.
// ----------------------------------------------------------------------------
module rsp_recip (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              in_vld,
  input  rsp_pkg::rsp_rot_t                 in_word,
  output logic                              out_vld,
  output rsp_pkg::rsp_carry_t               out_carry,
  output logic [rsp_pkg::SCALE_W-1:0]       out_scale
);
  import rsp_pkg::*;

  logic             vld_r   [QUO_W];
  logic [DIV_W-1:0] rem_r   [QUO_W];
  logic [QUO_W-1:0] quo_r   [QUO_W];
  logic [DIV_W-1:0] tzd_r   [QUO_W];
  rsp_carry_t       car_r   [QUO_W];

  logic             vld_in  [QUO_W];
  logic [DIV_W-1:0] rem_in  [QUO_W];
  logic [QUO_W-1:0] quo_in  [QUO_W];
  logic [DIV_W-1:0] tzd_in  [QUO_W];
  rsp_carry_t       car_in  [QUO_W];

  logic [QUO_W-1:0] quo_last;

  // Stage inputs: the numerator is a single one at its top bit
  assign vld_in[0] = in_vld;
  assign rem_in[0] = '0;
  assign quo_in[0] = '0;
  assign tzd_in[0] = in_word.tzd;
  assign car_in[0] = in_word.carry;

  for (genvar k = 1; k < QUO_W; k++) begin : g_link
    assign vld_in[k] = vld_r[k-1];
    assign rem_in[k] = rem_r[k-1];
    assign quo_in[k] = quo_r[k-1];
    assign tzd_in[k] = tzd_r[k-1];
    assign car_in[k] = car_r[k-1];
  end

  for (genvar k = 0; k < QUO_W; k++) begin : g_step
    logic [DIV_W:0] sh;
    logic [DIV_W:0] diff;
    logic           take;

    // Shift in the next numerator bit, subtract when it fits
    always_comb begin
      sh   = {rem_in[k], 1'(k == 0)};
      diff = sh - {1'b0, tzd_in[k]};
      take = sh >= {1'b0, tzd_in[k]};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_in[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= take ? diff[DIV_W-1:0] : sh[DIV_W-1:0];
        quo_r[k] <= {quo_in[k][QUO_W-2:0], take};
        tzd_r[k] <= tzd_in[k];
        car_r[k] <= car_in[k];
      end
    end
  end

  // Saturate the quotient to the scale width
  assign quo_last  = quo_r[QUO_W-1];
  assign out_scale = (|quo_last[QUO_W-1:SCALE_W]) ? '1 : quo_last[SCALE_W-1:0];
  assign out_vld   = vld_r[QUO_W-1];
  assign out_carry = car_r[QUO_W-1];

endmodule
`default_nettype wire

@@ hw/rtl/rsp_screen.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rsp_screen: scale products and screen mapping
// Four stages: ratio products, ratio sums and road width, screen products,
// final shift and saturation.
// ----------------------------------------------------------------------------
module rsp_screen (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              in_vld,
  input  rsp_pkg::rsp_carry_t               in_carry,
  input  logic [rsp_pkg::SCALE_W-1:0]       in_scale,
  input  logic [rsp_pkg::SW_W-1:0]          screen_width,
  input  logic [rsp_pkg::SW_W-1:0]          screen_height,
  input  logic [rsp_pkg::RWSW_W-1:0]        road_sw,
  output logic                              out_vld,
  output rsp_pkg::rsp_result_t              out_word
);
  import rsp_pkg::*;

  localparam int HI_W  = ROT_W - 24;
  localparam int XH_W  = HI_W + SCALE_W + 1;
  localparam int XL_W  = 24 + SCALE_W;
  localparam int R_W   = XH_W + 1;
  localparam int PW_W  = SCALE_W + RWSW_W;
  localparam int WS_W  = PW_W - W_SHIFT;
  localparam int A_W   = RATIO_W + 1;
  localparam int M_W   = A_W + SW_W + 1;
  localparam logic signed [R_W-1:0] R_MAX = (R_W'(1) <<< (RATIO_W - 1)) - R_W'(1);
  localparam logic signed [R_W-1:0] R_MIN = -(R_W'(1) <<< (RATIO_W - 1));
  localparam logic signed [A_W-1:0] ONE_V = A_W'(1 << FRAC_BITS);
  localparam logic signed [M_W-1:0] I32_MAX = M_W'(32'sh7FFF_FFFF);
  localparam logic signed [M_W-1:0] I32_MIN = -(M_W'(1) <<< 31);
  localparam logic signed [ROT_W-1:0] T32_MAX = ROT_W'(32'sh7FFF_FFFF);
  localparam logic signed [ROT_W-1:0] T32_MIN = -(ROT_W'(1) <<< 31);

  logic [3:0] vld_r;

  // First stage
  logic signed [ROT_W-1:0]  dye;
  logic signed [SCALE_W:0]  s_s;
  logic signed [XH_W-1:0]   pxh_r, pyh_r;
  logic [XL_W-1:0]          pxl_r, pyl_r;
  logic [PW_W-1:0]          pw_r;
  logic signed [ROT_W-1:0]  tx1_r;
  logic [30:0]              dep1_r, dep2_r, dep3_r;
  logic                     clp1_r, clp2_r, clp3_r;
  logic [SCALE_W-1:0]       sc1_r, sc2_r, sc3_r;

  // Second stage
  logic signed [R_W-1:0]     rx, ry;
  logic [WS_W-1:0]           wsh;
  logic signed [RATIO_W-1:0] rx_r, ry_r;
  logic [30:0]               w2_r, w3_r;
  logic signed [31:0]        lat2_r, lat3_r;

  // Third stage
  logic signed [A_W-1:0] ax, ay;
  logic signed [M_W-1:0] mx_r, my_r;

  // Fourth stage
  logic signed [M_W-1:0] hx, hy;
  rsp_result_t res_nxt, res_r;

  assign dye = ROT_W'(in_carry.dy);
  assign s_s = $signed({1'b0, in_scale});

  // Combine the high and low ratio products and clamp; cut the road width
  always_comb begin
    rx  = R_W'(pxh_r) + R_W'({1'b0, pxl_r[XL_W-1:24]});
    ry  = R_W'(pyh_r) + R_W'({1'b0, pyl_r[XL_W-1:24]});
    wsh = pw_r[PW_W-1:W_SHIFT];
  end

  // Screen offsets around the center
  always_comb begin
    ax = A_W'(rx_r) + ONE_V;
    ay = ONE_V - A_W'(ry_r);
  end

  // Halve and saturate
  always_comb begin
    hx = mx_r >>> 1;
    hy = my_r >>> 1;
    res_nxt.lateral  = lat3_r;
    res_nxt.depth    = dep3_r;
    res_nxt.clamped  = clp3_r;
    res_nxt.scale    = sc3_r;
    res_nxt.road_w   = w3_r;
    res_nxt.screen_x = (hx > I32_MAX) ? 32'sh7FFF_FFFF :
                       (hx < I32_MIN) ? 32'sh8000_0000 : hx[31:0];
    res_nxt.screen_y = (hy > I32_MAX) ? 32'sh7FFF_FFFF :
                       (hy < I32_MIN) ? 32'sh8000_0000 : hy[31:0];
  end

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[2:0], in_vld};
    end
  end

  // Data stages
  always_ff @(posedge clk) begin
    if (en) begin
      pxh_r  <= XH_W'($signed(in_carry.tx[ROT_W-1:24])) * XH_W'(s_s);
      pxl_r  <= XL_W'(in_carry.tx[23:0]) * XL_W'(in_scale);
      pyh_r  <= XH_W'($signed(dye[ROT_W-1:24])) * XH_W'(s_s);
      pyl_r  <= XL_W'(dye[23:0]) * XL_W'(in_scale);
      pw_r   <= PW_W'(in_scale) * PW_W'(road_sw);
      tx1_r  <= in_carry.tx;
      dep1_r <= in_carry.depth;
      clp1_r <= in_carry.clamped;
      sc1_r  <= in_scale;

      rx_r   <= (rx > R_MAX) ? R_MAX[RATIO_W-1:0] :
                (rx < R_MIN) ? R_MIN[RATIO_W-1:0] : rx[RATIO_W-1:0];
      ry_r   <= (ry > R_MAX) ? R_MAX[RATIO_W-1:0] :
                (ry < R_MIN) ? R_MIN[RATIO_W-1:0] : ry[RATIO_W-1:0];
      w2_r   <= (|wsh[WS_W-1:31]) ? '1 : wsh[30:0];
      lat2_r <= (tx1_r > T32_MAX) ? 32'sh7FFF_FFFF :
                (tx1_r < T32_MIN) ? 32'sh8000_0000 : tx1_r[31:0];
      dep2_r <= dep1_r;
      clp2_r <= clp1_r;
      sc2_r  <= sc1_r;

      mx_r   <= M_W'(ax) * M_W'($signed({1'b0, screen_width}));
      my_r   <= M_W'(ay) * M_W'($signed({1'b0, screen_height}));
      w3_r   <= w2_r;
      lat3_r <= lat2_r;
      dep3_r <= dep2_r;
      clp3_r <= clp2_r;
      sc3_r  <= sc2_r;

      res_r  <= res_nxt;
    end
  end

  assign out_vld  = vld_r[3];
  assign out_word = res_r;

endmodule
`default_nettype wire

@@ hw/rtl/road_segment_projection.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// road_segment_projection: pseudo-3D road projection of one segment point
// Rotates the camera offset by the heading, clamps the depth, takes its
// reciprocal and maps the point and the road width onto the screen.
// ----------------------------------------------------------------------------
//  channel | signals                           | words
//  --------+-----------------------------------+----------------------------
//  in      | in_valid/in_ready, seg x/y/z      | one segment point
//  out     | out_valid/out_ready, 7 fields     | one projection per point
//  cfg     | cfg_valid/cfg_ready, index, data  | one register write
//
//  Stages: 7 rotation stages, one divider stage per quotient bit (33)
//  and 4 screen stages. A new word enters every cycle unless held.
//  The whole pipeline holds while the output word waits; in_ready is low then.
//  Reset clears the valid bits and loads the register reset values.
//  cfg_ready is always high.
// ----------------------------------------------------------------------------
module road_segment_projection (
  input  logic                               clk,
  input  logic                               rst_n,
  // input words
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [31:0]                 in_seg_x,
  input  logic signed [31:0]                 in_seg_y,
  input  logic signed [31:0]                 in_seg_z,
  // result words
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [31:0]                 out_lateral,
  output logic [30:0]                        out_depth,
  output logic                               out_depth_clamped,
  output logic [rsp_pkg::SCALE_W-1:0]        out_scale,
  output logic signed [31:0]                 out_screen_x,
  output logic signed [31:0]                 out_screen_y,
  output logic [30:0]                        out_screen_road_width,
  // register writes
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [rsp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [31:0]                        cfg_data
);
  import rsp_pkg::*;

  localparam logic [SW_W-1:0] SCR_W_RST  = SW_W'(640);
  localparam logic [SW_W-1:0] SCR_H_RST  = SW_W'(480);
  localparam logic [RW_W-1:0] ROAD_W_RST = RW_W'(2000);

  logic signed [31:0]    cam_x_r, cam_y_r, cam_z_r;
  logic [ANGLE_BITS-1:0] heading_r;
  logic [SW_W-1:0]       scr_w_r, scr_h_r;
  logic [RW_W-1:0]       road_w_r;
  logic [RWSW_W-1:0]     road_sw_r;

  logic        en;
  logic        rot_vld, div_vld, scr_vld;
  rsp_rot_t    rot_word;
  rsp_carry_t  div_carry;
  logic [SCALE_W-1:0] div_scale;
  rsp_result_t res;

  // Advance the pipeline unless the output word is held
  assign en        = !scr_vld || out_ready;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;

  // Register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cam_x_r   <= '0;
      cam_y_r   <= '0;
      cam_z_r   <= '0;
      heading_r <= '0;
      scr_w_r   <= SCR_W_RST;
      scr_h_r   <= SCR_H_RST;
      road_w_r  <= ROAD_W_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_CAM_X:   cam_x_r   <= cfg_data;
        REG_CAM_Y:   cam_y_r   <= cfg_data;
        REG_CAM_Z:   cam_z_r   <= cfg_data;
        REG_HEADING: heading_r <= cfg_data[ANGLE_BITS-1:0];
        REG_SCR_W:   scr_w_r   <= cfg_data[SW_W-1:0];
        REG_SCR_H:   scr_h_r   <= cfg_data[SW_W-1:0];
        REG_ROAD_W:  road_w_r  <= cfg_data[RW_W-1:0];
        default: ;
      endcase
    end
  end

  // Road width times screen width; settles long before a word needs it
  always_ff @(posedge clk) begin
    road_sw_r <= RWSW_W'(road_w_r) * RWSW_W'(scr_w_r);
  end

  rsp_rotate u_rotate (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (in_valid),
    .seg_x    (in_seg_x),
    .seg_y    (in_seg_y),
    .seg_z    (in_seg_z),
    .cam_x    (cam_x_r),
    .cam_y    (cam_y_r),
    .cam_z    (cam_z_r),
    .heading  (heading_r),
    .out_vld  (rot_vld),
    .out_word (rot_word)
  );

  rsp_recip u_recip (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_vld    (rot_vld),
    .in_word   (rot_word),
    .out_vld   (div_vld),
    .out_carry (div_carry),
    .out_scale (div_scale)
  );

  rsp_screen u_screen (
    .clk           (clk),
    .rst_n         (rst_n),
    .en            (en),
    .in_vld        (div_vld),
    .in_carry      (div_carry),
    .in_scale      (div_scale),
    .screen_width  (scr_w_r),
    .screen_height (scr_h_r),
    .road_sw       (road_sw_r),
    .out_vld       (scr_vld),
    .out_word      (res)
  );

  // Drive the result word
  assign out_valid             = scr_vld;
  assign out_lateral           = res.lateral;
  assign out_depth             = res.depth;
  assign out_depth_clamped     = res.clamped;
  assign out_scale             = res.scale;
  assign out_screen_x          = res.screen_x;
  assign out_screen_y          = res.screen_y;
  assign out_screen_road_width = res.road_w;

endmodule
`default_nettype wire

@@ tb/sv/road_segment_projection_tb.sv @@
// ----------------------------------------------------------------------------
// road_segment_projection_tb: self-checking bench of the segment projection
// Streams segment points under changing camera and screen settings, predicts
// every projection in the bench and compares each result word field by field.
// ----------------------------------------------------------------------------
module road_segment_projection_tb;
  import rsp_pkg::*;

  localparam int  CYCLE_LIMIT   = 400000;
  localparam int  RANDOM_POINTS = 750;
  localparam longint DEPTH_MIN  = ((64'sd1 << FRAC_BITS) + 5) / 10;
  localparam longint RATIO_LIM  = 64'sd1 << 40;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] in_seg_x = '0;
  logic signed [31:0] in_seg_y = '0;
  logic signed [31:0] in_seg_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_lateral;
  logic [30:0] out_depth;
  logic out_depth_clamped;
  logic [SCALE_W-1:0] out_scale;
  logic signed [31:0] out_screen_x;
  logic signed [31:0] out_screen_y;
  logic [30:0] out_screen_road_width;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  // camera and screen settings as the bench believes them
  longint cam_x_m, cam_y_m, cam_z_m;
  logic [11:0] heading_m;
  logic [12:0] scr_w_m, scr_h_m;
  logic [15:0] road_w_m;

  rsp_result_t projections_due[$];
  int mismatches = 0;
  int cycles = 0;
  int send_idle_max = 0;
  int recv_idle_max = 0;

  road_segment_projection DUT (.*);

  always #1 clk = ~clk;

  // time out a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("** road_segment_projection: FAILED **");
      $finish;
    end
  end

  function automatic longint sin_q16(input logic [15:0] ph);
    longint x, x2, t;
    x  = ph[14] ? 64'sd16384 - longint'(ph[13:0]) : longint'(ph[13:0]);
    x2 = (x * x) >>> 14;
    t  = (SIN_C * x2) >>> 14;
    t  = SIN_B - t;
    t  = (t * x2) >>> 14;
    t  = SIN_A - t;
    t  = (t * x) >>> 14;
    return ph[15] ? -t : t;
  endfunction

  // floor(a * s / 2^24) limited to +-2^40
  function automatic longint scaled_offset(input longint a, input longint s);
    longint mag, r;
    mag = (a < 0) ? -a : a;
    if (s != 0 && mag > (64'sd1 << 62) / s) return (a < 0) ? -RATIO_LIM : RATIO_LIM;
    r = (a * s) >>> 24;
    if (r > RATIO_LIM) r = RATIO_LIM;
    if (r < -RATIO_LIM) r = -RATIO_LIM;
    return r;
  endfunction

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic rsp_result_t project_point(input logic signed [31:0] sx_in,
                                                input logic signed [31:0] sy_in,
                                                input logic signed [31:0] sz_in);
    rsp_result_t res;
    longint dx, dy, dz, s, c, tx, tz, sc, sx, sy, w;
    logic [15:0] ph;
    logic clamped;
    dx = longint'(sx_in) - cam_x_m * 256;
    dy = longint'(sy_in) - cam_y_m * 256;
    dz = longint'(sz_in) - cam_z_m * 256;
    ph = {heading_m, 4'b0000};
    s  = sin_q16(ph);
    c  = sin_q16(ph + 16'd16384);
    tx = (dx * c + dz * s) >>> 16;
    tz = (dz * c - dx * s) >>> 16;
    clamped = (tz < DEPTH_MIN);
    if (clamped) tz = DEPTH_MIN;
    sc = (64'sd1 << (24 + FRAC_BITS)) / tz;
    if (sc > 64'sh0FFFFFFF) sc = 64'sh0FFFFFFF;
    sx = ((256 + scaled_offset(tx, sc)) * longint'(scr_w_m)) >>> 1;
    sy = ((256 - scaled_offset(dy, sc)) * longint'(scr_h_m)) >>> 1;
    w  = (sc * longint'(road_w_m) * longint'(scr_w_m)) >>> W_SHIFT;
    res.lateral  = 32'(clip(tx, -64'sh80000000, 64'sh7FFFFFFF));
    res.depth    = 31'(clip(tz, 0, 64'sh7FFFFFFF));
    res.clamped  = clamped;
    res.scale    = SCALE_W'(sc);
    res.screen_x = 32'(clip(sx, -64'sh80000000, 64'sh7FFFFFFF));
    res.screen_y = 32'(clip(sy, -64'sh80000000, 64'sh7FFFFFFF));
    res.road_w   = 31'(clip(w, 0, 64'sh7FFFFFFF));
    return res;
  endfunction

  task automatic report(input string field, input longint got, input longint want);
    mismatches++;
    $display("mismatch %s: got %0d expected %0d (cycle %0d)", field, got, want, cycles);
  endtask

  // accept result words and compare against the oldest prediction
  initial begin : result_checker
    int gap;
    rsp_result_t want;
    forever begin
      gap = $urandom_range(0, recv_idle_max);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!(out_valid && rst_n)) @(posedge clk);
      if (projections_due.size() == 0) begin
        report("unexpected word", 0, 0);
      end else begin
        want = projections_due.pop_front();
        if (out_lateral !== want.lateral) report("lateral", out_lateral, want.lateral);
        if (out_depth !== want.depth) report("depth", out_depth, want.depth);
        if (out_depth_clamped !== want.clamped)
          report("depth_clamped", out_depth_clamped, want.clamped);
        if (out_scale !== want.scale) report("scale", out_scale, want.scale);
        if (out_screen_x !== want.screen_x) report("screen_x", out_screen_x, want.screen_x);
        if (out_screen_y !== want.screen_y) report("screen_y", out_screen_y, want.screen_y);
        if (out_screen_road_width !== want.road_w)
          report("screen_road_width", out_screen_road_width, want.road_w);
      end
    end
  end

  task automatic send_point(input logic signed [31:0] x, input logic signed [31:0] y,
                            input logic signed [31:0] z);
    int gap;
    gap = $urandom_range(0, send_idle_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_seg_x <= x;
    in_seg_y <= y;
    in_seg_z <= z;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    projections_due.insert(projections_due.size(), project_point(x, y, z));
  endtask

  // let the pipeline empty before touching registers
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (projections_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_CAM_X:   cam_x_m = longint'(signed'(data));
      REG_CAM_Y:   cam_y_m = longint'(signed'(data));
      REG_CAM_Z:   cam_z_m = longint'(signed'(data));
      REG_HEADING: heading_m = data[11:0];
      REG_SCR_W:   scr_w_m = data[12:0];
      REG_SCR_H:   scr_h_m = data[12:0];
      REG_ROAD_W:  road_w_m = data[15:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_camera(input int x, input int y, input int z, input int hd);
    drain();
    write_reg(REG_CAM_X, x);
    write_reg(REG_CAM_Y, y);
    write_reg(REG_CAM_Z, z);
    write_reg(REG_HEADING, hd);
  endtask

  task automatic set_screen(input int w, input int h, input int rw);
    drain();
    write_reg(REG_SCR_W, w);
    write_reg(REG_SCR_H, h);
    write_reg(REG_ROAD_W, rw);
  endtask

  // points in front of the camera at reset settings
  task automatic test_reset_values();
    send_point(32'sd0, 32'sd0, 32'sd25600);
    send_point(32'sd2560, -32'sd512, 32'sd256);
    send_point(32'sd0, 32'sd0, 32'sd26);
  endtask

  // field extremes, quarter headings, clamp and saturation corners
  task automatic test_extremes();
    send_point(32'h80000000, 32'h80000000, 32'h80000000);
    send_point(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
    send_point(32'h7FFFFFFF, 32'h80000000, 32'sd26);
    send_point(32'h80000000, 32'h7FFFFFFF, 32'sd25);
    send_point(32'sd0, 32'sd0, -32'sd1000);
    set_camera(100, 5, -200, 1024);
    send_point(32'sd25600, 32'sd1280, 32'sd0);
    set_camera(0, 0, 0, 2048);
    send_point(32'sd0, 32'sd0, -32'sd12800);
    drain();
    write_reg(REG_HEADING, 3072);
    send_point(32'sd0, 32'sd0, 32'sd12800);
    drain();
    write_reg(REG_HEADING, 32'hFFFF_FFFF);
    write_reg(REG_UNUSED, 32'h1234_5678);
    send_point(32'sd1000, 32'sd200, 32'sd50000);
    set_camera(32'h7FFFFFFF, 32'h80000000, 32'h80000000, 512);
    send_point(32'sd0, 32'sd0, 32'sd0);
    set_camera(32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 0);
    send_point(32'h7FFFFFFF, 32'sd0, 32'h80000000);
    set_screen(0, 0, 0);
    set_camera(0, 0, 0, 0);
    send_point(32'sd5000, 32'sd300, 32'sd26);
    set_screen(4096, 4096, 65535);
    send_point(32'sd0, 32'sd0, 32'sd26);
    send_point(32'sh7FFFFFFF, -32'sd700000, 32'sd30);
    set_screen(8191, 8191, 1);
    send_point(-32'sd9000000, 32'sd9000000, 32'sd26);
    set_screen(1, 1, 2000);
    send_point(32'sd256, 32'sd256, 32'sd256);
  endtask

  function automatic int pick_coord();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 2) == 0 ? 32'h7FFFFFFF : 32'h80000000;
      default: return int'($urandom_range(0, 2000)) - 1000;
    endcase
  endfunction

  // points mostly ahead of a relocated camera plus fully random points, with random settings between phases
  task automatic test_random_stream();
    int n, kind;
    longint bx, by, bz;
    for (n = 0; n < RANDOM_POINTS; n++) begin
      if (n % 75 == 0) begin
        send_idle_max = ($urandom_range(0, 2) == 0) ? 0 : 16;
        recv_idle_max = ($urandom_range(0, 2) == 0) ? 0 : 16;
        set_camera(pick_coord(), pick_coord(), pick_coord(), $urandom_range(0, 4095));
        set_screen($urandom_range(0, 3) == 0 ? $urandom_range(0, 8191) : $urandom_range(1, 4096),
                   $urandom_range(0, 3) == 0 ? $urandom_range(0, 8191) : $urandom_range(1, 4096),
                   $urandom_range(0, 65535));
      end
      kind = $urandom_range(0, 9);
      if (kind < 2) begin
        send_point($urandom, $urandom, $urandom);
      end else begin
        bx = cam_x_m * 256 + (longint'($urandom_range(0, 2097152)) - 1048576);
        by = cam_y_m * 256 + (longint'($urandom_range(0, 65536)) - 32768);
        bz = cam_z_m * 256 + (longint'($urandom_range(0, 4194304)) - 4096);
        send_point(bx[31:0], by[31:0], bz[31:0]);
      end
    end
  endtask

  initial begin
    cam_x_m = 0; cam_y_m = 0; cam_z_m = 0;
    heading_m = '0;
    scr_w_m = 13'd640; scr_h_m = 13'd480; road_w_m = 16'd2000;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_values();
    test_extremes();
    test_random_stream();
    in_valid <= 1'b0;
    while (projections_due.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (mismatches == 0) begin
      $display("** road_segment_projection: PASSED **");
    end else begin
      $display("** road_segment_projection: FAILED **");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/rsp_pkg.sv
hw/rtl/rsp_trig.sv
hw/rtl/rsp_rotate.sv
hw/rtl/rsp_recip.sv
hw/rtl/rsp_screen.sv
hw/rtl/road_segment_projection.sv
tb/sv/road_segment_projection_tb.sv
